### hdl/iirdf2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared widths, coefficient reset values, register codes, command types and
// the saturation helper of the saturating direct form II IIR filter.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

	localparam int ORDER     = 2;
	localparam int MAX_TAPS  = 3;
	localparam int FRAC_BITS = 10;
	localparam int DATA_W    = 11;
	localparam int COEF_W    = 11;
	localparam int NUM_REGS  = 7;
	localparam int IDX_W     = $clog2(NUM_REGS);

	localparam int PROD_W = DATA_W + COEF_W;
	localparam int SHF_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = SHF_W + 2;

	localparam int SAT_MAX = 2 ** (DATA_W - 1) - 1;

	localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(430);
	localparam logic signed [COEF_W-1:0] B1_RESET = COEF_W'(430);
	localparam logic signed [COEF_W-1:0] A1_RESET = COEF_W'(-163);

	typedef enum logic [IDX_W-1:0] {
		REG_B0 = IDX_W'(0),
		REG_B1 = IDX_W'(1),
		REG_B2 = IDX_W'(2),
		REG_B3 = IDX_W'(3),
		REG_A1 = IDX_W'(4),
		REG_A2 = IDX_W'(5),
		REG_A3 = IDX_W'(6)
	} reg_idx_t;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic [COEF_W-1:0]                b0;
		logic [MAX_TAPS-1:0][COEF_W-1:0]  b_tap;
		logic [MAX_TAPS-1:0][COEF_W-1:0]  a_tap;
	} coef_set_t;

	typedef struct packed {
		logic load_in;
		logic sum;
		logic out_load;
	} dp_cmd_t;

	function automatic sample_t sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(SAT_MAX);
		lo = -hi;
		if (v > hi) begin
			return DATA_W'(hi);
		end else if (v < lo) begin
			return DATA_W'(lo);
		end
		return DATA_W'(v);
	endfunction

endpackage

### hdl/iirdf2_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_in_if
// Request channel that carries one input sample.
// ----------------------------------------------------------------------------
interface iirdf2_in_if import iirdf2_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

### hdl/iirdf2_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_out_if
// Request channel that carries one filtered sample.
// ----------------------------------------------------------------------------
interface iirdf2_out_if import iirdf2_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

### hdl/iirdf2_coef_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_coef_regs
// Coefficient register file, written through the plain write port.
// ----------------------------------------------------------------------------
module iirdf2_coef_regs import iirdf2_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [COEF_W-1:0] cfg_data,
	output coef_set_t         coef
);

	coef_set_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0    <= B0_RESET;
			coef_q.b_tap <= {{(2*COEF_W){1'b0}}, B1_RESET};
			coef_q.a_tap <= {{(2*COEF_W){1'b0}}, A1_RESET};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_B0: coef_q.b0 <= cfg_data;
				REG_B1: coef_q.b_tap[0] <= cfg_data;
				REG_B2: coef_q.b_tap[1] <= cfg_data;
				REG_B3: coef_q.b_tap[2] <= cfg_data;
				REG_A1: coef_q.a_tap[0] <= cfg_data;
				REG_A2: coef_q.a_tap[1] <= cfg_data;
				REG_A3: coef_q.a_tap[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

### hdl/iirdf2_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_ctrl
// Sequencer: accept, sum taps, load the output register.
// ----------------------------------------------------------------------------
module iirdf2_ctrl import iirdf2_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   in_fire;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_OUT) && out_free);
	assign in_fire  = in_valid && in_ready;

	assign cmd.load_in  = in_fire;
	assign cmd.sum      = (state_q == ST_SUM);
	assign cmd.out_load = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= in_fire ? ST_SUM : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/iirdf2_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_datapath
// Tap products, saturating feedback and feedforward sums, delay line and
// output register.
// ----------------------------------------------------------------------------
module iirdf2_datapath import iirdf2_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  coef_set_t coef,
	input  sample_t   sample_in,
	output sample_t   sample_out
);

	sample_t                   delay_q [ORDER];
	sample_t                   x_s1;
	logic signed [SHF_W-1:0]   fbp_s1 [ORDER];
	logic signed [SHF_W-1:0]   ffp_s1 [ORDER];
	sample_t                   w_s2;
	sample_t                   ff_s2;
	sample_t                   out_q;

	logic signed [SHF_W-1:0]   fbp [ORDER];
	logic signed [SHF_W-1:0]   ffp [ORDER];
	sample_t                   fb_sum;
	sample_t                   ff_sum;
	sample_t                   w_val;
	logic signed [PROD_W-1:0]  y_prod;
	sample_t                   y_val;

	always_comb begin
		logic signed [PROD_W-1:0] pa;
		logic signed [PROD_W-1:0] pb;
		for (int k = 0; k < ORDER; k++) begin
			pa = PROD_W'(delay_q[k]) * PROD_W'(coef_t'(coef.a_tap[k]));
			pb = PROD_W'(delay_q[k]) * PROD_W'(coef_t'(coef.b_tap[k]));
			fbp[k] = SHF_W'(pa >>> FRAC_BITS);
			ffp[k] = SHF_W'(pb >>> FRAC_BITS);
		end
	end

	always_comb begin
		sample_t fb;
		sample_t ff;
		fb = '0;
		ff = '0;
		for (int k = 0; k < ORDER; k++) begin
			fb = sat(SUM_W'(fb) - SUM_W'(fbp_s1[k]));
			ff = sat(SUM_W'(ff) + SUM_W'(ffp_s1[k]));
		end
		fb_sum = fb;
		ff_sum = ff;
		w_val  = sat(SUM_W'(x_s1) + SUM_W'(fb_sum));
	end

	assign y_prod = PROD_W'(w_s2) * PROD_W'(coef_t'(coef.b0));
	assign y_val  = sat(SUM_W'(SHF_W'(y_prod >>> FRAC_BITS)) + SUM_W'(ff_s2));

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_s1   <= sample_in;
			fbp_s1 <= fbp;
			ffp_s1 <= ffp;
		end
		if (cmd.sum) begin
			w_s2  <= w_val;
			ff_s2 <= ff_sum;
		end
		if (cmd.out_load) begin
			out_q <= y_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ORDER; k++) begin
				delay_q[k] <= '0;
			end
		end else if (cmd.sum) begin
			for (int k = ORDER - 1; k > 0; k--) begin
				delay_q[k] <= delay_q[k-1];
			end
			delay_q[0] <= w_val;
		end
	end

	assign sample_out = out_q;

endmodule

### hdl/iir_direct_form_ii_saturating.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_direct_form_ii_saturating
// Saturating direct form II IIR filter, one filtered sample per input sample.
//
//   channel   role     payload       width
//   in_ch     sink     sample_in     11 signed
//   out_ch    source   sample_out    11 signed
//   cfg_*     write    cfg_data      11, index cfg_idx
//
// A sample is accepted while idle or as the last result loads; the result
// goes via the sum state to the output register. The tap products use the
// delay line, updated in the sum cycle, so the next sample waits for that
// update. A stalled output holds the result and blocks the load of the next
// one. Reset clears the delay line and restores the coefficient reset values.
// ----------------------------------------------------------------------------
module iir_direct_form_ii_saturating import iirdf2_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [COEF_W-1:0] cfg_data,
	iirdf2_in_if.sink         in_ch,
	iirdf2_out_if.source      out_ch
);

	coef_set_t coef;
	dp_cmd_t   cmd;

	iirdf2_coef_regs u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coef     (coef)
	);

	iirdf2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	iirdf2_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.coef       (coef),
		.sample_in  (in_ch.sample_in),
		.sample_out (out_ch.sample_out)
	);

endmodule

### hdl/iirdf2_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_checker
// Port-level checks of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module iirdf2_checker import iirdf2_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input sample_t sample_out
);

	logic in_fire;

	assign in_fire = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("output request dropped or changed under stall");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_out != sample_t'(-SAT_MAX - 1))
		else $error("output sample outside saturation range");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted during the sum cycle");

	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_fire, 3))
		else $error("result appeared without a matching request");

endmodule

bind iir_direct_form_ii_saturating iirdf2_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);
